// File: design/eegcd_pkg.sv
// Shared definitions for the extended Euclid gcd unit: field widths, default
// width and the microcode control word with its program ROM.
// No dependencies.
package eegcd_pkg;

	// operand and coefficient widths of the transfer fields
	localparam int unsigned OPND_W     = 31;
	localparam int unsigned COEF_W     = 32;
	localparam int unsigned DEF_WIDTH  = 32;
	localparam int unsigned DIV_CNT_W  = $clog2(OPND_W);

	// microcode address
	localparam int unsigned UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UA_WAIT    = 4'd0;
	localparam upc_t UA_TEST    = 4'd1;
	localparam upc_t UA_DIVINIT = 4'd2;
	localparam upc_t UA_DIVSTEP = 4'd3;
	localparam upc_t UA_STORE   = 4'd4;
	localparam upc_t UA_BTEST   = 4'd5;
	localparam upc_t UA_MUL     = 4'd6;
	localparam upc_t UA_SUB     = 4'd7;
	localparam upc_t UA_OUT     = 4'd8;

	// datapath operation of one step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_STORE,
		OP_BREAD,
		OP_MUL,
		OP_SUB,
		OP_EMIT
	} uop_t;

	// sequencing: fall through, jump, hold until flag, branch on flag
	typedef enum logic [1:0] {
		C_NEXT,
		C_GOTO,
		C_HOLD,
		C_BRANCH
	} cond_t;

	// status flag tested by the sequencer
	typedef enum logic [2:0] {
		F_NONE,
		F_IN,
		F_DIV_LAST,
		F_OUT_FREE,
		F_EUCLID_DONE,
		F_STEPS_ZERO
	} flag_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		flag_t flag;
		upc_t  target;
	} ctrl_word_t;

	// program ROM
	function automatic ctrl_word_t ucode_rom(input upc_t addr);
		ctrl_word_t cw;
		unique case (addr)
			UA_WAIT:    cw = '{OP_LOAD,    C_HOLD,   F_IN,          UA_TEST};
			UA_TEST:    cw = '{OP_NONE,    C_BRANCH, F_EUCLID_DONE, UA_BTEST};
			UA_DIVINIT: cw = '{OP_DIVINIT, C_NEXT,   F_NONE,        UA_DIVSTEP};
			UA_DIVSTEP: cw = '{OP_DIVSTEP, C_HOLD,   F_DIV_LAST,    UA_STORE};
			UA_STORE:   cw = '{OP_STORE,   C_GOTO,   F_NONE,        UA_TEST};
			UA_BTEST:   cw = '{OP_BREAD,   C_BRANCH, F_STEPS_ZERO,  UA_OUT};
			UA_MUL:     cw = '{OP_MUL,     C_NEXT,   F_NONE,        UA_SUB};
			UA_SUB:     cw = '{OP_SUB,     C_GOTO,   F_NONE,        UA_BTEST};
			UA_OUT:     cw = '{OP_EMIT,    C_HOLD,   F_OUT_FREE,    UA_WAIT};
			default:    cw = '{OP_NONE,    C_GOTO,   F_NONE,        UA_WAIT};
		endcase
		return cw;
	endfunction

endpackage

// File: design/extended_euclid_gcd_unit.sv
// Extended Euclid gcd unit: microcoded sequencer over a serial divider,
// a quotient store and a coefficient back-substitution datapath.
// Depends on eegcd_pkg.
//
// Usage
//  - Input channel (in_valid / in_stall): one transfer carries a pair
//    first_operand, second_operand (31-bit unsigned). in_stall is low only
//    while the sequencer sits in its wait step.
//  - Output channel (out_valid / out_stall): one transfer per input carries
//    divisor = gcd(a, b) and signed coeff_first, coeff_second with
//    a*coeff_first + b*coeff_second = divisor.
//  - The work per pair grows with N, the number of Euclid steps
//    (N = 0 when b is zero, N <= 46 for 31-bit operands). Each step is
//    dominated by the restoring divider, which retires one quotient bit per
//    cycle; back-substitution costs a read, a multiply and a subtract per
//    step.
//  - One pair is in work at a time. The result sits in an output register,
//    so the next pair is taken while the previous result is still stalled.
//  - Reset (arst_n low) drops any pair in work, clears out_valid and returns
//    the sequencer to its wait step. No state is kept between pairs.
//  - WIDTH bounds the Euclid iteration to 2*WIDTH+2 steps and sizes the
//    quotient store accordingly.
module extended_euclid_gcd_unit
	import eegcd_pkg::*;
#(
	parameter int unsigned WIDTH = DEF_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OPND_W-1:0]        first_operand,
	input  logic [OPND_W-1:0]        second_operand,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [OPND_W-1:0]        divisor,
	output logic signed [COEF_W-1:0] coeff_first,
	output logic signed [COEF_W-1:0] coeff_second
);

	localparam int unsigned MAX_STEPS = 2 * WIDTH + 2;
	localparam int unsigned IDX_W     = $clog2(MAX_STEPS);
	localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1);

	// sequencer
	upc_t       upc_q;
	upc_t       upc_nxt;
	ctrl_word_t cw;
	logic       flag_val;

	// Euclid datapath
	logic [OPND_W-1:0]    a_q;
	logic [OPND_W-1:0]    b_q;
	logic [STEP_W-1:0]    steps_q;
	logic [STEP_W-1:0]    steps_dec;
	logic                 euclid_done;

	// serial divider
	logic [OPND_W-1:0]    rem_q;
	logic [OPND_W-1:0]    dq_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [OPND_W:0]      div_shift;
	logic                 div_ge;
	logic                 div_last;

	// quotient store and back-substitution
	logic [OPND_W-1:0]    quot_mem [MAX_STEPS];
	logic [OPND_W-1:0]    rd_q;
	logic [COEF_W-1:0]    cx_q;
	logic [COEF_W-1:0]    cy_q;
	logic [COEF_W-1:0]    prod_q;
	logic [COEF_W-1:0]    prod_full;

	// output register
	logic                     out_valid_q;
	logic [OPND_W-1:0]        divisor_q;
	logic signed [COEF_W-1:0] coeff_first_q;
	logic signed [COEF_W-1:0] coeff_second_q;

	logic in_xfer;
	logic out_free;

	assign cw = ucode_rom(upc_q);

	// handshakes
	assign in_stall = (cw.op != OP_LOAD);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// status flags
	assign euclid_done = (b_q == '0) || (steps_q == STEP_W'(MAX_STEPS));
	assign div_last    = (div_cnt_q == DIV_CNT_W'(OPND_W - 1));
	assign steps_dec   = steps_q - STEP_W'(1);

	always_comb begin
		unique case (cw.flag)
			F_IN:          flag_val = in_xfer;
			F_DIV_LAST:    flag_val = div_last;
			F_OUT_FREE:    flag_val = out_free;
			F_EUCLID_DONE: flag_val = euclid_done;
			F_STEPS_ZERO:  flag_val = (steps_q == '0);
			default:       flag_val = 1'b0;
		endcase
	end

	// next microcode address: hold stays put until the flag rises
	always_comb begin
		unique case (cw.cond)
			C_NEXT:   upc_nxt = upc_q + upc_t'(1);
			C_GOTO:   upc_nxt = cw.target;
			C_HOLD:   upc_nxt = flag_val ? cw.target : upc_q;
			C_BRANCH: upc_nxt = flag_val ? cw.target : upc_q + upc_t'(1);
			default:  upc_nxt = UA_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_WAIT;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	// restoring divider step: shift in the next dividend bit, subtract if it fits
	assign div_shift = {rem_q, dq_q[OPND_W-1]};
	assign div_ge    = (div_shift >= {1'b0, b_q});

	// low half of the product is all that the 32-bit coefficients need
	assign prod_full = {{(COEF_W - OPND_W){1'b0}}, rd_q} * cy_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (cw.op)
				OP_LOAD: begin
					if (in_xfer) begin
						steps_q <= '0;
					end
				end
				OP_DIVINIT: div_cnt_q <= '0;
				OP_DIVSTEP: div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				OP_STORE:   steps_q   <= steps_q + STEP_W'(1);
				OP_BREAD: begin
					if (steps_q != '0) begin
						steps_q <= steps_dec;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (in_xfer) begin
					a_q  <= first_operand;
					b_q  <= second_operand;
					cx_q <= COEF_W'(1);
					cy_q <= '0;
				end
			end
			OP_DIVINIT: begin
				rem_q <= '0;
				dq_q  <= a_q;
			end
			OP_DIVSTEP: begin
				if (div_ge) begin
					rem_q <= OPND_W'(div_shift - {1'b0, b_q});
				end else begin
					rem_q <= div_shift[OPND_W-1:0];
				end
				dq_q <= {dq_q[OPND_W-2:0], div_ge};
			end
			OP_STORE: begin
				// advance the recurrence: (a, b) <- (b, a mod b)
				a_q <= b_q;
				b_q <= rem_q;
			end
			OP_MUL: prod_q <= prod_full;
			OP_SUB: begin
				// x = y', y = x' - q*y'
				cx_q <= cy_q;
				cy_q <= cx_q - prod_q;
			end
			default: begin
			end
		endcase
	end

	// quotient store: written forward, read back in reverse order
	always_ff @(posedge clk) begin
		if (cw.op == OP_STORE) begin
			quot_mem[steps_q[IDX_W-1:0]] <= dq_q;
		end
		if (cw.op == OP_BREAD && steps_q != '0) begin
			rd_q <= quot_mem[steps_dec[IDX_W-1:0]];
		end
	end

	// output register: load when free, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && out_free) begin
			divisor_q      <= a_q;
			coeff_first_q  <= $signed(cx_q);
			coeff_second_q <= $signed(cy_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign divisor      = divisor_q;
	assign coeff_first  = coeff_first_q;
	assign coeff_second = coeff_second_q;

`ifndef SYNTHESIS
	a_load_leaves_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> upc_q == UA_TEST)
		else $error("sequencer did not leave the wait step after an input transfer");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == UA_DIVSTEP |-> b_q != '0)
		else $error("divider running with a zero divisor");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == UA_STORE |-> rem_q < b_q)
		else $error("remainder not below divisor at quotient store");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_W'(MAX_STEPS))
		else $error("Euclid step count beyond its bound");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UA_OUT && out_free) |=> out_valid)
		else $error("result emitted without raising out_valid");
`endif

endmodule

// File: bench/extended_euclid_gcd_unit_tb.sv
// Self-checking bench for extended_euclid_gcd_unit: a queue-fed driver and a
// result monitor against a behavioral extended-Euclid predictor.
// Depends on eegcd_pkg and the extended_euclid_gcd_unit RTL.
`timescale 1ns / 1ps

module extended_euclid_gcd_unit_tb
	import eegcd_pkg::*;
;

	localparam int unsigned CLK_PERIOD = 8;
	// the Euclid loop is bounded by 2*WIDTH+2 steps; the uut runs with its default WIDTH
	localparam int unsigned STEP_BOUND = 2 * DEF_WIDTH + 2;
	localparam int unsigned RAND_PAIRS = 390;
	// worst case for one pair: longest latency plus both sides' longest bursts and some slack
	localparam int unsigned WORST_CYCLES = 1705 + 12 + 12 + 16;
	localparam int unsigned CYCLE_LIMIT = (RAND_PAIRS + 40) * WORST_CYCLES * 4;
	localparam int unsigned DRAIN_CYCLES = 1800;
	// number of transfers at the end that run with no idling on either side
	localparam int unsigned QUIET_TAIL = 60;

	typedef struct packed {
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
	} pair_t;

	typedef struct packed {
		logic [OPND_W-1:0]        d;
		logic signed [COEF_W-1:0] x;
		logic signed [COEF_W-1:0] y;
	} bezout_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OPND_W-1:0]        first_operand = '0;
	logic [OPND_W-1:0]        second_operand = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [OPND_W-1:0]        divisor;
	logic signed [COEF_W-1:0] coeff_first;
	logic signed [COEF_W-1:0] coeff_second;

	pair_t       pairs_to_send[$];
	bezout_t     bezout_due[$];
	logic [30:0] fib [0:46];

	int unsigned total_pairs = 0;
	int unsigned sent_cnt = 0;
	int unsigned taken_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	logic        in_xfer = 1'b0;
	logic        idle_en = 1'b1;

	extended_euclid_gcd_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.first_operand (first_operand),
		.second_operand(second_operand),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.divisor       (divisor),
		.coeff_first   (coeff_first),
		.coeff_second  (coeff_second)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Extended Euclid: run the quotient/remainder recurrence forward while
	// logging each quotient, then back-substitute from x=1, y=0 at the last
	// nonzero dividend. Coefficient math wraps at 64 bits and keeps the low 32.
	function automatic bezout_t extended_gcd(input pair_t p);
		logic [63:0]  dividend;
		logic [63:0]  dvsr;
		logic [63:0]  rem;
		logic [63:0]  cx;
		logic [63:0]  cy;
		logic [63:0]  nx;
		logic [63:0]  quots [STEP_BOUND];
		int unsigned  n;
		bezout_t      res;
		dividend = {33'd0, p.a};
		dvsr = {33'd0, p.b};
		n = 0;
		while (dvsr != 0 && n < STEP_BOUND) begin
			quots[n] = dividend / dvsr;
			rem = dividend % dvsr;
			n++;
			dividend = dvsr;
			dvsr = rem;
		end
		cx = 64'd1;
		cy = 64'd0;
		while (n > 0) begin
			n--;
			nx = cy;
			cy = cx - quots[n] * cy;
			cx = nx;
		end
		res.d = dividend[OPND_W-1:0];
		res.x = cx[COEF_W-1:0];
		res.y = cy[COEF_W-1:0];
		return res;
	endfunction

	task automatic flag_error(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_cnt++;
	endtask

	task automatic queue_pair(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
		pair_t p;
		p.a = a;
		p.b = b;
		pairs_to_send.push_back(p);
		total_pairs++;
	endtask

	// Input driver. Change the payload only when nothing is presented or the
	// last rising edge completed a transfer; otherwise hold it as it is.
	// After a transfer, sometimes insert an idle burst before the next pair.
	always @(negedge clk) begin
		logic  next_valid;
		pair_t p;
		if (arst_n && (!in_valid || in_xfer)) begin
			next_valid = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
			end else if (pairs_to_send.size() > 0) begin
				p = pairs_to_send.pop_front();
				first_operand <= p.a;
				second_operand <= p.b;
				next_valid = 1'b1;
				sent_cnt++;
				// switch all idling off for the closing stretch of transfers
				if (sent_cnt + QUIET_TAIL >= total_pairs)
					idle_en = 1'b0;
				if (idle_en && $urandom_range(0, 5) == 0)
					in_gap = $urandom_range(1, 12);
			end
			in_valid <= next_valid;
		end
	end

	// Output back-pressure: random stall bursts, applied whether or not a
	// result is waiting so bursts land on every phase.
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (arst_n && idle_en && $urandom_range(0, 9) == 0)
				out_gap = $urandom_range(1, 12);
		end
	end

	// Monitor. On an input transfer, predict the result and queue it; on an
	// output transfer, check it field by field against the oldest prediction.
	always @(posedge clk) begin
		bezout_t want;
		pair_t   p;
		in_xfer <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			p.a = first_operand;
			p.b = second_operand;
			bezout_due.push_back(extended_gcd(p));
			taken_cnt++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (bezout_due.size() == 0) begin
				flag_error($sformatf("result d=%0d x=%0d y=%0d with no pair outstanding",
					divisor, coeff_first, coeff_second));
			end else begin
				want = bezout_due.pop_front();
				if (divisor !== want.d)
					flag_error($sformatf("divisor got %0d want %0d", divisor, want.d));
				if (coeff_first !== want.x)
					flag_error($sformatf("coeff_first got %0d want %0d",
						coeff_first, want.x));
				if (coeff_second !== want.y)
					flag_error($sformatf("coeff_second got %0d want %0d",
						coeff_second, want.y));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("extended_euclid_gcd_unit test failed");
			$finish;
		end
	end

	initial begin
		logic [31:0]       raw_a;
		logic [31:0]       raw_b;
		logic [OPND_W-1:0] max_opnd;
		int unsigned       kind;
		int unsigned       k;
		int unsigned       idx;
		max_opnd = '1;

		fib[0] = 31'd0;
		fib[1] = 31'd1;
		for (int i = 2; i <= 46; i++)
			fib[i] = fib[i-1] + fib[i-2];

		// Directed pairs: zero operands, extremes, ordering, worst-case
		// step count (consecutive Fibonacci numbers), common factors.
		queue_pair(31'd0, 31'd0);
		queue_pair(31'd12345, 31'd0);
		queue_pair(31'd0, 31'd6789);
		queue_pair(max_opnd, 31'd0);
		queue_pair(31'd0, max_opnd);
		queue_pair(max_opnd, max_opnd);
		queue_pair(31'd1, 31'd1);
		queue_pair(max_opnd, 31'd1);
		queue_pair(31'd1, max_opnd);
		queue_pair(31'd18, 31'd12);
		queue_pair(31'd12, 31'd18);
		queue_pair(31'd300, 31'd100);
		queue_pair(31'd100, 31'd300);
		queue_pair(max_opnd, max_opnd - 31'd1);
		queue_pair(max_opnd - 31'd1, max_opnd);
		queue_pair(fib[46], fib[45]);
		queue_pair(fib[45], fib[46]);
		queue_pair(31'h5555_5555, 31'h2AAA_AAAA);
		queue_pair(31'h2AAA_AAAA, 31'h5555_5555);
		queue_pair(31'h4000_0000, 31'h2000_0000);
		queue_pair(31'd987654, 31'd987654);
		queue_pair(max_opnd, 31'h4000_0000);

		// Random pairs: mostly full-width, plus shared factors, small values,
		// a zero operand, and Fibonacci pairs for long iteration chains.
		for (int i = 0; i < RAND_PAIRS; i++) begin
			raw_a = $urandom();
			raw_b = $urandom();
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				queue_pair(raw_a[30:0], raw_b[30:0]);
			end else if (kind < 72) begin
				k = $urandom_range(1, 65535);
				queue_pair(31'(k * $urandom_range(0, 32767)),
					31'(k * $urandom_range(0, 32767)));
			end else if (kind < 84) begin
				queue_pair(31'($urandom_range(0, 255)), 31'($urandom_range(0, 255)));
			end else if (kind < 90) begin
				if (raw_b[31])
					queue_pair(raw_a[30:0], 31'd0);
				else
					queue_pair(31'd0, raw_a[30:0]);
			end else begin
				idx = $urandom_range(2, 46);
				if (raw_b[31])
					queue_pair(fib[idx], fib[idx-1]);
				else
					queue_pair(fib[idx-1], fib[idx]);
			end
		end

		// hold reset, then release it on a falling edge
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// wait for every pair to be taken and every result to come back
		while (taken_cnt < total_pairs || bezout_due.size() != 0)
			@(posedge clk);
		// let any stray result surface before closing
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bezout_due.size() != 0)
			flag_error($sformatf("%0d results never arrived", bezout_due.size()));

		if (err_cnt == 0)
			$display("extended_euclid_gcd_unit test passed");
		else
			$display("extended_euclid_gcd_unit test failed");
		$finish;
	end

endmodule
